// ===== hw/rtl/lcdf_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdf_pkg
// Types, codes and helpers shared by the 8080-style LCD transaction framer.
// ----------------------------------------------------------------------------
package lcdf_pkg;

   localparam int COUNT_W = 24;
   localparam int MAX_WORDS = 3;

   // item modes
   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   // data formats
   localparam logic [1:0] FMT_8   = 2'd0;
   localparam logic [1:0] FMT_16  = 2'd1;
   localparam logic [1:0] FMT_RGB = 2'd2;
   localparam logic [1:0] FMT_RSV = 2'd3;

   // command sizes
   localparam logic [1:0] CSZ_NONE = 2'd0;
   localparam logic [1:0] CSZ_ONE  = 2'd1;
   localparam logic [1:0] CSZ_TWO  = 2'd2;
   localparam logic [1:0] CSZ_RSV  = 2'd3;

   typedef struct packed {
      logic [1:0]         mode;
      logic [15:0]        command;
      logic [1:0]         cmd_size;
      logic [1:0]         data_format;
      logic               fill;
      logic               is_read;
      logic [COUNT_W-1:0] count;
      logic [7:0]         dummy_count;
      logic [15:0]        pixel;
      logic [7:0]         bus_byte;
   } item_type;

   typedef struct packed {
      logic        reg_select;
      logic        write_strobe;
      logic [7:0]  byte_out;
      logic        pixel_valid;
      logic [15:0] pixel_out;
      logic        last;
      logic        error;
   } word_type;

   // results of one item, slot 0 goes out first
   typedef struct packed {
      word_type [MAX_WORDS-1:0] words;
      logic [1:0]               count;
   } bundle_type;

   function automatic word_type bus_word(input logic rs, input logic wr,
                                         input logic [7:0] b, input logic last);
      word_type w;
      w = '0;
      w.reg_select   = rs;
      w.write_strobe = wr;
      w.byte_out     = b;
      w.last         = last;
      return w;
   endfunction

   function automatic word_type error_word();
      word_type w;
      w = '0;
      w.error = 1'b1;
      return w;
   endfunction

endpackage

// ===== hw/rtl/lcdf_ifs.sv =====
// ----------------------------------------------------------------------------
// lcdf channel interfaces
// Request, response and register-write channels with valid/ready.
// ----------------------------------------------------------------------------
interface lcdf_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [15:0] command;
   logic [1:0]  cmd_size;
   logic [1:0]  data_format;
   logic        fill;
   logic        is_read;
   logic [23:0] count;
   logic [7:0]  dummy_count;
   logic [15:0] pixel;
   logic [7:0]  bus_byte;

   modport source (output valid, mode, command, cmd_size, data_format, fill, is_read,
                   count, dummy_count, pixel, bus_byte, input ready);
   modport sink (input valid, mode, command, cmd_size, data_format, fill, is_read,
                 count, dummy_count, pixel, bus_byte, output ready);
endinterface

interface lcdf_rsp_if;
   logic        valid;
   logic        ready;
   logic        reg_select;
   logic        write_strobe;
   logic [7:0]  byte_out;
   logic        pixel_valid;
   logic [15:0] pixel_out;
   logic        last;
   logic        error;

   modport source (output valid, reg_select, write_strobe, byte_out, pixel_valid,
                   pixel_out, last, error, input ready);
   modport sink (input valid, reg_select, write_strobe, byte_out, pixel_valid,
                 pixel_out, last, error, output ready);
endinterface

interface lcdf_csr_if;
   logic valid;
   logic ready;
   logic rgb24_order;

   modport source (output valid, rgb24_order, input ready);
   modport sink (input valid, rgb24_order, output ready);
endinterface

// ===== hw/rtl/parallel_lcd_transaction_framer_top.sv =====
// ----------------------------------------------------------------------------
// parallel_lcd_transaction_framer_top
// Frames command and pixel transactions for an 8-bit 8080-style LCD bus.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake       payload
//   req_if   in   valid / ready   mode, command, sizes, count, pixel, bus_byte
//   rsp_if   out  valid / ready   one bus byte / read pixel / last / error
//   csr_if   in   valid / ready   rgb24_order (always ready)
//
// Flow: a request word goes into the input register and is decoded
//   combinationally into 1 to 3 response words that load the result
//   register, which drives rsp_if. Rate: a request word is taken only
//   once the result register is empty or its last word is leaving; the
//   register drains one word a cycle while rsp_if.ready is high.
// Stalls: rsp_if.ready low holds the result register; the input register
//   still takes one more word. Reset is synchronous and clears all control state.
//
module parallel_lcd_transaction_framer_top #(
   parameter int COUNT_BITS   = 24,
   parameter int READ_SUPPORT = 1
) (
   input  logic       clock,
   input  logic       reset,
   lcdf_req_if.sink   req_if,
   lcdf_rsp_if.source rsp_if,
   lcdf_csr_if.sink   csr_if
);

   lcdf_pkg::item_type   req_item;
   lcdf_pkg::item_type   held_item;
   lcdf_pkg::bundle_type bundle;
   lcdf_pkg::word_type   rsp_word;
   logic                 held_valid;
   logic                 load_ok;
   logic                 fire;
   logic                 rgb24_order_ff;

   // pack request payload
   assign req_item.mode        = req_if.mode;
   assign req_item.command     = req_if.command;
   assign req_item.cmd_size    = req_if.cmd_size;
   assign req_item.data_format = req_if.data_format;
   assign req_item.fill        = req_if.fill;
   assign req_item.is_read     = req_if.is_read;
   assign req_item.count       = req_if.count;
   assign req_item.dummy_count = req_if.dummy_count;
   assign req_item.pixel       = req_if.pixel;
   assign req_item.bus_byte    = req_if.bus_byte;

   // engine consumes the held word once the result register can take it
   assign fire = held_valid && load_ok;

   // register write: the user must write only while idle; the block does not enforce it, no interlock
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rgb24_order_ff <= 1'b0;
      end else if (csr_if.valid) begin
         rgb24_order_ff <= csr_if.rgb24_order;
      end
   end

   lcdf_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_if.valid),
      .in_ready   (req_if.ready),
      .in_item    (req_item),
      .take       (fire),
      .held_valid (held_valid),
      .held_item  (held_item)
   );

   lcdf_engine #(
      .COUNT_BITS   (COUNT_BITS),
      .READ_SUPPORT (READ_SUPPORT)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .item        (held_item),
      .rgb24_order (rgb24_order_ff),
      .bundle      (bundle)
   );

   lcdf_out_queue u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .bundle    (bundle),
      .load_ok   (load_ok),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_word  (rsp_word)
   );

   // unpack response word
   assign rsp_if.reg_select   = rsp_word.reg_select;
   assign rsp_if.write_strobe = rsp_word.write_strobe;
   assign rsp_if.byte_out     = rsp_word.byte_out;
   assign rsp_if.pixel_valid  = rsp_word.pixel_valid;
   assign rsp_if.pixel_out    = rsp_word.pixel_out;
   assign rsp_if.last         = rsp_word.last;
   assign rsp_if.error        = rsp_word.error;

`ifndef SYNTH
   // a held request word is never dropped before the engine takes it
   a_held_kept: assert property (@(posedge clock) disable iff (reset)
      held_valid && !fire |=> held_valid)
      else $error("input register lost a word");

   // read pixels are data-phase words with no write strobe
   a_pixel_is_read: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.pixel_valid |-> rsp_if.reg_select && !rsp_if.write_strobe)
      else $error("read pixel on a write or command word");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_if.valid)
      else $error("response valid after reset");
`endif

endmodule

// ===== hw/rtl/lcdf_in_stage.sv =====
// ----------------------------------------------------------------------------
// lcdf_in_stage
// Input register: holds one request word until the engine takes it.
// ----------------------------------------------------------------------------
module lcdf_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  lcdf_pkg::item_type in_item,
   input  logic               take,
   output logic               held_valid,
   output lcdf_pkg::item_type held_item
);

   logic               valid_ff;
   logic               valid_in;
   lcdf_pkg::item_type item_ff;

   assign in_ready   = !valid_ff || take;
   assign valid_in   = (in_valid && in_ready) || (valid_ff && !take);
   assign held_valid = valid_ff;
   assign held_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

// ===== hw/rtl/lcdf_engine.sv =====
// ----------------------------------------------------------------------------
// lcdf_engine
// Transaction state and per-word decode: builds up to three bus words.
// ----------------------------------------------------------------------------
module lcdf_engine #(
   parameter int COUNT_BITS   = 24,
   parameter int READ_SUPPORT = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  lcdf_pkg::item_type   item,
   input  logic                 rgb24_order,
   output lcdf_pkg::bundle_type bundle
);

   logic                  active_ff, active_in;
   logic                  is_read_ff, is_read_in;
   logic [1:0]            format_ff, format_in;
   logic                  fill_ff, fill_in;
   logic [COUNT_BITS-1:0] left_ff, left_in;
   logic [7:0]            dummies_ff, dummies_in;
   logic [15:0]           fill_value_ff, fill_value_in;
   logic [1:0]            rd_idx_ff, rd_idx_in;
   logic [15:0]           partial_ff, partial_in;

   logic [31:0]           cnt_wide;
   logic [COUNT_BITS-1:0] cnt;
   logic [COUNT_BITS-1:0] left_dec;
   logic                  left_done;

   assign cnt_wide  = {{(32 - lcdf_pkg::COUNT_W){1'b0}}, item.count};
   assign cnt       = cnt_wide[COUNT_BITS-1:0];
   assign left_dec  = left_ff - {{(COUNT_BITS-1){1'b0}}, 1'b1};
   assign left_done = (left_dec == '0);

   always_comb begin
      logic        fin;
      logic [1:0]  csz;
      logic [1:0]  fmt;
      logic [15:0] v;
      logic [7:0]  r8, g8, b8, hi, lo;
      logic [15:0] px;

      active_in     = active_ff;
      is_read_in    = is_read_ff;
      format_in     = format_ff;
      fill_in       = fill_ff;
      left_in       = left_ff;
      dummies_in    = dummies_ff;
      fill_value_in = fill_value_ff;
      rd_idx_in     = rd_idx_ff;
      partial_in    = partial_ff;
      bundle        = '0;
      bundle.count  = 2'd1;
      fin = 1'b0;
      csz = 2'd0;
      fmt = 2'd0;
      v   = 16'd0;
      r8  = 8'd0;
      g8  = 8'd0;
      b8  = 8'd0;
      hi  = 8'd0;
      lo  = 8'd0;
      px  = 16'd0;

      case (item.mode)
         lcdf_pkg::MODE_START: begin
            if (active_ff || (item.is_read && (READ_SUPPORT == 0))) begin
               bundle.words[0] = lcdf_pkg::error_word();
            end else begin
               csz = (item.cmd_size == lcdf_pkg::CSZ_RSV) ? lcdf_pkg::CSZ_TWO : item.cmd_size;
               fmt = (item.data_format == lcdf_pkg::FMT_RSV) ? lcdf_pkg::FMT_16
                                                              : item.data_format;
               fin = (cnt == '0);
               case (csz)
                  lcdf_pkg::CSZ_TWO: begin
                     bundle.words[0] = lcdf_pkg::bus_word(1'b0, 1'b1, item.command[15:8], 1'b0);
                     bundle.words[1] = lcdf_pkg::bus_word(1'b0, 1'b1, item.command[7:0], fin);
                     bundle.count    = 2'd2;
                  end
                  lcdf_pkg::CSZ_ONE: begin
                     bundle.words[0] = lcdf_pkg::bus_word(1'b0, 1'b1, item.command[7:0], fin);
                  end
                  default: begin
                     bundle.words[0] = lcdf_pkg::bus_word(1'b0, 1'b0, 8'd0, fin);
                  end
               endcase
               if (!fin) begin
                  active_in     = 1'b1;
                  is_read_in    = item.is_read;
                  format_in     = fmt;
                  fill_in       = item.fill;
                  left_in       = cnt;
                  dummies_in    = item.dummy_count;
                  fill_value_in = item.pixel;
                  rd_idx_in     = 2'd0;
                  partial_in    = 16'd0;
               end
            end
         end

         lcdf_pkg::MODE_WRITE: begin
            if (!active_ff || is_read_ff) begin
               bundle.words[0] = lcdf_pkg::error_word();
            end else begin
               v   = fill_ff ? fill_value_ff : item.pixel;
               fin = left_done;
               r8  = {v[15:11], 3'b000};
               g8  = {v[10:5], 2'b00};
               b8  = {v[4:0], 3'b000};
               left_in = left_dec;
               if (fin) begin
                  active_in = 1'b0;
               end
               case (format_ff)
                  lcdf_pkg::FMT_8: begin
                     bundle.words[0] = lcdf_pkg::bus_word(1'b1, 1'b1, v[7:0], fin);
                  end
                  lcdf_pkg::FMT_RGB: begin
                     bundle.words[0] = lcdf_pkg::bus_word(1'b1, 1'b1,
                                                          rgb24_order ? r8 : b8, 1'b0);
                     bundle.words[1] = lcdf_pkg::bus_word(1'b1, 1'b1, g8, 1'b0);
                     bundle.words[2] = lcdf_pkg::bus_word(1'b1, 1'b1,
                                                          rgb24_order ? b8 : r8, fin);
                     bundle.count    = 2'd3;
                  end
                  default: begin
                     bundle.words[0] = lcdf_pkg::bus_word(1'b1, 1'b1, v[15:8], 1'b0);
                     bundle.words[1] = lcdf_pkg::bus_word(1'b1, 1'b1, v[7:0], fin);
                     bundle.count    = 2'd2;
                  end
               endcase
            end
         end

         lcdf_pkg::MODE_READ: begin
            if (!active_ff || !is_read_ff || (READ_SUPPORT == 0)) begin
               bundle.words[0] = lcdf_pkg::error_word();
            end else if (dummies_ff != 8'd0) begin
               dummies_in      = dummies_ff - 8'd1;
               bundle.words[0] = lcdf_pkg::bus_word(1'b1, 1'b0, 8'd0, 1'b0);
            end else if ((format_ff == lcdf_pkg::FMT_16) && (rd_idx_ff == 2'd0)) begin
               partial_in      = {item.bus_byte, 8'd0};
               rd_idx_in       = 2'd1;
               bundle.words[0] = lcdf_pkg::bus_word(1'b1, 1'b0, 8'd0, 1'b0);
            end else if ((format_ff == lcdf_pkg::FMT_RGB) && (rd_idx_ff != 2'd2)) begin
               if (rd_idx_ff == 2'd0) begin
                  partial_in = partial_ff | {8'd0, item.bus_byte};
               end else begin
                  partial_in = partial_ff | {item.bus_byte, 8'd0};
               end
               rd_idx_in       = rd_idx_ff + 2'd1;
               bundle.words[0] = lcdf_pkg::bus_word(1'b1, 1'b0, 8'd0, 1'b0);
            end else begin
               case (format_ff)
                  lcdf_pkg::FMT_8: begin
                     px = {8'd0, item.bus_byte};
                  end
                  lcdf_pkg::FMT_RGB: begin
                     hi = rgb24_order ? partial_ff[7:0] : item.bus_byte;
                     lo = rgb24_order ? item.bus_byte : partial_ff[7:0];
                     px = {hi[7:3], partial_ff[15:10], lo[7:3]};
                  end
                  default: begin
                     px = partial_ff | {8'd0, item.bus_byte};
                  end
               endcase
               fin        = left_done;
               rd_idx_in  = 2'd0;
               partial_in = 16'd0;
               left_in    = left_dec;
               if (fin) begin
                  active_in = 1'b0;
               end
               bundle.words[0]             = lcdf_pkg::bus_word(1'b1, 1'b0, 8'd0, fin);
               bundle.words[0].pixel_valid = 1'b1;
               bundle.words[0].pixel_out   = px;
            end
         end

         default: begin
            bundle.words[0] = lcdf_pkg::error_word();
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         is_read_ff    <= 1'b0;
         format_ff     <= lcdf_pkg::FMT_8;
         fill_ff       <= 1'b0;
         left_ff       <= '0;
         dummies_ff    <= 8'd0;
         fill_value_ff <= 16'd0;
         rd_idx_ff     <= 2'd0;
         partial_ff    <= 16'd0;
      end else if (fire) begin
         active_ff     <= active_in;
         is_read_ff    <= is_read_in;
         format_ff     <= format_in;
         fill_ff       <= fill_in;
         left_ff       <= left_in;
         dummies_ff    <= dummies_in;
         fill_value_ff <= fill_value_in;
         rd_idx_ff     <= rd_idx_in;
         partial_ff    <= partial_in;
      end
   end

endmodule

// ===== hw/rtl/lcdf_out_queue.sv =====
// ----------------------------------------------------------------------------
// lcdf_out_queue
// Result register: holds one item's words, hands one out per ready cycle.
// ----------------------------------------------------------------------------
module lcdf_out_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  lcdf_pkg::bundle_type bundle,
   output logic                 load_ok,
   output logic                 out_valid,
   input  logic                 out_ready,
   output lcdf_pkg::word_type   out_word
);

   logic [1:0]                                     count_ff, count_in;
   lcdf_pkg::word_type [lcdf_pkg::MAX_WORDS-1:0]   words_ff, words_in;
   logic                                           take;

   assign out_valid = (count_ff != 2'd0);
   assign out_word  = words_ff[0];
   assign take      = out_valid && out_ready;
   assign load_ok   = (count_ff == 2'd0) || ((count_ff == 2'd1) && take);

   always_comb begin
      count_in = count_ff;
      words_in = words_ff;
      if (load) begin
         count_in = bundle.count;
         words_in = bundle.words;
      end else if (take) begin
         count_in    = count_ff - 2'd1;
         words_in[0] = words_ff[1];
         words_in[1] = words_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      words_ff <= words_in;
   end

endmodule

// ===== tb/sv/parallel_lcd_transaction_framer_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parallel_lcd_transaction_framer_top_tb
// Self-checking bench for the 8080-style LCD transaction framer: a short
// directed run, then random transactions mixed with stray items under random
// stalls on both channels, one long response hold-off and rgb24_order changes
// between phases. Every response word is checked against a cycle-free model.
// ----------------------------------------------------------------------------
module parallel_lcd_transaction_framer_top_tb;

   localparam int         LIMIT_CYCLES = 400000;
   localparam int         DRAIN_CYCLES = 8;     // settle margin after the last word
   localparam int         HOLD_CYCLES  = 120;   // long response back-pressure
   localparam int         PHASE_ITEMS  = 50;
   localparam int         NUM_PHASES   = 6;
   localparam logic [1:0] MODE_BAD     = 2'd3;  // no such mode, always refused

   typedef logic [lcdf_pkg::COUNT_W-1:0] count_type;

   // -------------------------------------------------------------------------
   // Expected-word model: tracks the open transaction and queues the bus,
   // pixel, last and error words each accepted request word should produce.
   // -------------------------------------------------------------------------
   class lcd_frame_scoreboard;
      lcdf_pkg::word_type pending[$];
      int                 failures;
      bit                 order;       // rgb24_order as last written
      bit                 open;        // transaction in progress
      bit                 rd_phase;
      logic [1:0]         fmt;
      bit                 fill_on;
      count_type          left;
      logic [7:0]         dummies;
      logic [15:0]        fill_px;
      logic [1:0]         byte_idx;
      logic [15:0]        partial;

      function new();
         failures = 0;
         order    = 1'b0;
         open     = 1'b0;
         rd_phase = 1'b0;
         fmt      = lcdf_pkg::FMT_8;
         fill_on  = 1'b0;
         left     = '0;
         dummies  = '0;
         fill_px  = '0;
         byte_idx = '0;
         partial  = '0;
      endfunction

      function void push_word(logic rs, logic wr, logic [7:0] b, logic pv,
                              logic [15:0] px, logic last, logic err);
         lcdf_pkg::word_type w;
         w.reg_select   = rs;
         w.write_strobe = wr;
         w.byte_out     = b;
         w.pixel_valid  = pv;
         w.pixel_out    = px;
         w.last         = last;
         w.error        = err;
         pending.push_back(w);
      endfunction

      function void push_error();
         push_word(1'b0, 1'b0, 8'h00, 1'b0, 16'h0000, 1'b0, 1'b1);
      endfunction

      function void note_item(lcdf_pkg::item_type it);
         logic [1:0]  csz;
         logic [1:0]  f;
         logic [15:0] v;
         logic [15:0] px;
         logic [7:0]  r8;
         logic [7:0]  g8;
         logic [7:0]  b8;
         logic [7:0]  hi;
         logic [7:0]  lo;
         bit          done;
         case (it.mode)
            lcdf_pkg::MODE_START: begin
               if (open) begin
                  push_error();
                  return;
               end
               csz  = (it.cmd_size == lcdf_pkg::CSZ_RSV) ? lcdf_pkg::CSZ_TWO : it.cmd_size;
               f    = (it.data_format == lcdf_pkg::FMT_RSV) ? lcdf_pkg::FMT_16
                                                           : it.data_format;
               done = (it.count == '0);
               if (csz == lcdf_pkg::CSZ_TWO)
                  push_word(1'b0, 1'b1, it.command[15:8], 1'b0, 16'h0000, 1'b0, 1'b0);
               if (csz != lcdf_pkg::CSZ_NONE)
                  push_word(1'b0, 1'b1, it.command[7:0], 1'b0, 16'h0000, done, 1'b0);
               else
                  push_word(1'b0, 1'b0, 8'h00, 1'b0, 16'h0000, done, 1'b0);
               if (!done) begin
                  open     = 1'b1;
                  rd_phase = it.is_read;
                  fmt      = f;
                  fill_on  = it.fill;
                  left     = it.count;
                  dummies  = it.dummy_count;
                  fill_px  = it.pixel;
                  byte_idx = '0;
                  partial  = '0;
               end
            end
            lcdf_pkg::MODE_WRITE: begin
               if (!open || rd_phase) begin
                  push_error();
                  return;
               end
               v    = fill_on ? fill_px : it.pixel;
               left = left - 1'b1;
               done = (left == '0);
               if (fmt == lcdf_pkg::FMT_8) begin
                  push_word(1'b1, 1'b1, v[7:0], 1'b0, 16'h0000, done, 1'b0);
               end else if (fmt == lcdf_pkg::FMT_16) begin
                  push_word(1'b1, 1'b1, v[15:8], 1'b0, 16'h0000, 1'b0, 1'b0);
                  push_word(1'b1, 1'b1, v[7:0], 1'b0, 16'h0000, done, 1'b0);
               end else begin
                  // 565 widened to 888, low bits zero
                  r8 = {v[15:11], 3'b000};
                  g8 = {v[10:5], 2'b00};
                  b8 = {v[4:0], 3'b000};
                  push_word(1'b1, 1'b1, order ? r8 : b8, 1'b0, 16'h0000, 1'b0, 1'b0);
                  push_word(1'b1, 1'b1, g8, 1'b0, 16'h0000, 1'b0, 1'b0);
                  push_word(1'b1, 1'b1, order ? b8 : r8, 1'b0, 16'h0000, done, 1'b0);
               end
               if (done)
                  open = 1'b0;
            end
            lcdf_pkg::MODE_READ: begin
               if (!open || !rd_phase) begin
                  push_error();
                  return;
               end
               if (dummies != '0) begin
                  dummies = dummies - 1'b1;
                  push_word(1'b1, 1'b0, 8'h00, 1'b0, 16'h0000, 1'b0, 1'b0);
                  return;
               end
               if (fmt == lcdf_pkg::FMT_8) begin
                  px = {8'h00, it.bus_byte};
               end else if (fmt == lcdf_pkg::FMT_16) begin
                  if (byte_idx == 2'd0) begin
                     partial  = {it.bus_byte, 8'h00};
                     byte_idx = 2'd1;
                     push_word(1'b1, 1'b0, 8'h00, 1'b0, 16'h0000, 1'b0, 1'b0);
                     return;
                  end
                  px = partial | {8'h00, it.bus_byte};
               end else begin
                  if (byte_idx < 2'd2) begin
                     if (byte_idx == 2'd0)
                        partial[7:0] = it.bus_byte;
                     else
                        partial[15:8] = it.bus_byte;
                     byte_idx = byte_idx + 1'b1;
                     push_word(1'b1, 1'b0, 8'h00, 1'b0, 16'h0000, 1'b0, 1'b0);
                     return;
                  end
                  // first and third bytes swap roles with the order bit
                  hi = order ? partial[7:0] : it.bus_byte;
                  lo = order ? it.bus_byte : partial[7:0];
                  px = {hi[7:3], partial[15:10], lo[7:3]};
               end
               byte_idx = '0;
               partial  = '0;
               left     = left - 1'b1;
               done     = (left == '0);
               if (done)
                  open = 1'b0;
               push_word(1'b1, 1'b0, 8'h00, 1'b1, px, done, 1'b0);
            end
            default: begin
               push_error();
            end
         endcase
      endfunction

      function void check_field(string name, logic [15:0] want, logic [15:0] got);
         if (want !== got) begin
            failures++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      function void check_word(lcdf_pkg::word_type got);
         lcdf_pkg::word_type want;
         if (pending.size() == 0) begin
            failures++;
            $display("%0t: unexpected word, expected none, actual %p", $time, got);
            return;
         end
         want = pending.pop_front();
         check_field("reg_select", 16'(want.reg_select), 16'(got.reg_select));
         check_field("write_strobe", 16'(want.write_strobe), 16'(got.write_strobe));
         check_field("byte_out", 16'(want.byte_out), 16'(got.byte_out));
         check_field("pixel_valid", 16'(want.pixel_valid), 16'(got.pixel_valid));
         check_field("pixel_out", want.pixel_out, got.pixel_out);
         check_field("last", 16'(want.last), 16'(got.last));
         check_field("error", 16'(want.error), 16'(got.error));
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset, channels and the block
   // -------------------------------------------------------------------------
   logic clock;
   logic reset;

   lcdf_req_if req_ch ();
   lcdf_rsp_if rsp_ch ();
   lcdf_csr_if csr_ch ();

   parallel_lcd_transaction_framer_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   lcd_frame_scoreboard sb;
   bit                  steady;        // phase with no idle cycles on either side
   bit                  hold_pending;  // asks the response side for one long stall
   int                  cycles;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run watchdog
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT_CYCLES) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic int draw_gap();
      return steady ? 0 : int'($urandom_range(0, 9));
   endfunction

   // all fields random; callers pin the ones that matter
   function automatic lcdf_pkg::item_type random_item(input logic [1:0] mode);
      lcdf_pkg::item_type it;
      it.mode        = mode;
      it.command     = 16'($urandom);
      it.cmd_size    = 2'($urandom);
      it.data_format = 2'($urandom);
      it.fill        = 1'($urandom);
      it.is_read     = 1'($urandom);
      it.count       = count_type'($urandom);
      it.dummy_count = 8'($urandom);
      it.pixel       = 16'($urandom);
      it.bus_byte    = 8'($urandom);
      return it;
   endfunction

   // -------------------------------------------------------------------------
   // Request side. valid stays high across back-to-back words; it drops for
   // a drawn idle gap or a drain, so valid sees one update per step.
   // -------------------------------------------------------------------------
   task automatic send_item(input lcdf_pkg::item_type it);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.mode        <= it.mode;
      req_ch.command     <= it.command;
      req_ch.cmd_size    <= it.cmd_size;
      req_ch.data_format <= it.data_format;
      req_ch.fill        <= it.fill;
      req_ch.is_read     <= it.is_read;
      req_ch.count       <= it.count;
      req_ch.dummy_count <= it.dummy_count;
      req_ch.pixel       <= it.pixel;
      req_ch.bus_byte    <= it.bus_byte;
      req_ch.valid       <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_item(it);
   endtask

   task automatic send_start(input logic [1:0] csz, input logic [1:0] fmt,
                             input logic fl, input logic rd,
                             input count_type cnt, input logic [7:0] dum,
                             input logic [15:0] cmd, input logic [15:0] px);
      lcdf_pkg::item_type it;
      it             = random_item(lcdf_pkg::MODE_START);
      it.cmd_size    = csz;
      it.data_format = fmt;
      it.fill        = fl;
      it.is_read     = rd;
      it.count       = cnt;
      it.dummy_count = dum;
      it.command     = cmd;
      it.pixel       = px;
      send_item(it);
   endtask

   task automatic send_data(input logic [1:0] mode, input logic [15:0] px,
                            input logic [7:0] b);
      lcdf_pkg::item_type it;
      it          = random_item(mode);
      it.pixel    = px;
      it.bus_byte = b;
      send_item(it);
   endtask

   // stop offering, let every expected word come back, then settle
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // register write, only with the block quiet
   task automatic write_order(input bit v);
      wait_drained();
      csr_ch.rgb24_order <= v;
      csr_ch.valid       <= 1'b1;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      sb.order = v;
   endtask

   // Random traffic: mostly well-formed transactions driven from the model's
   // view of the open phase, with stray words that the block must refuse.
   // Refused words do not count toward n_items. Ends on a closed transaction.
   task automatic random_phase(input int n_items);
      int                 counted;
      int                 pick;
      lcdf_pkg::item_type it;
      counted = 0;
      while (counted < n_items || sb.open) begin
         pick = int'($urandom_range(0, 99));
         if (pick < 8) begin
            it = random_item(MODE_BAD);
            if (sb.open) begin
               case ($urandom_range(0, 2))
                  0: it.mode = lcdf_pkg::MODE_START;
                  1: it.mode = MODE_BAD;
                  default: it.mode = sb.rd_phase ? lcdf_pkg::MODE_WRITE
                                                 : lcdf_pkg::MODE_READ;
               endcase
            end else begin
               case ($urandom_range(0, 2))
                  0: it.mode = lcdf_pkg::MODE_WRITE;
                  1: it.mode = lcdf_pkg::MODE_READ;
                  default: it.mode = MODE_BAD;
               endcase
            end
            send_item(it);
         end else if (!sb.open) begin
            send_start(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                       1'($urandom), 1'($urandom),
                       ($urandom_range(0, 9) == 0) ? count_type'(0)
                                                   : count_type'($urandom_range(1, 5)),
                       ($urandom_range(0, 39) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(0, 3)),
                       16'($urandom), 16'($urandom));
            counted++;
         end else begin
            send_data(sb.rd_phase ? lcdf_pkg::MODE_READ : lcdf_pkg::MODE_WRITE,
                      16'($urandom), 8'($urandom));
            counted++;
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Response side: random ready gaps per word, and one long hold-off when
   // asked, counted here while the request side keeps pushing.
   // -------------------------------------------------------------------------
   initial begin
      lcdf_pkg::word_type got;
      int                 gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_pending) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_pending = 1'b0;
         end else begin
            gap = draw_gap();
            if (gap > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         got.reg_select   = rsp_ch.reg_select;
         got.write_strobe = rsp_ch.write_strobe;
         got.byte_out     = rsp_ch.byte_out;
         got.pixel_valid  = rsp_ch.pixel_valid;
         got.pixel_out    = rsp_ch.pixel_out;
         got.last         = rsp_ch.last;
         got.error        = rsp_ch.error;
         sb.check_word(got);
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      sb           = new();
      steady       = 1'b0;
      hold_pending = 1'b0;

      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.mode        <= lcdf_pkg::MODE_START;
      req_ch.command     <= '0;
      req_ch.cmd_size    <= lcdf_pkg::CSZ_NONE;
      req_ch.data_format <= lcdf_pkg::FMT_8;
      req_ch.fill        <= 1'b0;
      req_ch.is_read     <= 1'b0;
      req_ch.count       <= '0;
      req_ch.dummy_count <= '0;
      req_ch.pixel       <= '0;
      req_ch.bus_byte    <= '0;
      rsp_ch.ready       <= 1'b0;
      csr_ch.valid       <= 1'b0;
      csr_ch.rgb24_order <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part, red byte first ----
      write_order(1'b1);
      // two command bytes, one full-scale 565 pixel out as 888
      send_start(lcdf_pkg::CSZ_TWO, lcdf_pkg::FMT_RGB, 1'b0, 1'b0, count_type'(1), 8'd0,
                 16'hFFFF, 16'h0000);
      send_data(lcdf_pkg::MODE_WRITE, 16'hFFFF, 8'h00);
      // one command byte, fill of two 8-bit elements ignores the new pixels
      send_start(lcdf_pkg::CSZ_ONE, lcdf_pkg::FMT_8, 1'b1, 1'b0, count_type'(2), 8'd0,
                 16'h0000, 16'hA5C3);
      send_data(lcdf_pkg::MODE_WRITE, 16'h1234, 8'h00);
      send_data(lcdf_pkg::MODE_WRITE, 16'hFFFF, 8'h00);
      // reserved command size and reserved format fold to two bytes / 16-bit
      send_start(lcdf_pkg::CSZ_RSV, lcdf_pkg::FMT_RSV, 1'b0, 1'b0, count_type'(1), 8'd0,
                 16'h8001, 16'h0000);
      send_data(lcdf_pkg::MODE_WRITE, 16'h0000, 8'h00);
      // zero count: bare last, then last on the low command byte
      send_start(lcdf_pkg::CSZ_NONE, lcdf_pkg::FMT_8, 1'b0, 1'b0, count_type'(0), 8'd0,
                 16'h0000, 16'h0000);
      send_start(lcdf_pkg::CSZ_TWO, lcdf_pkg::FMT_16, 1'b0, 1'b0, count_type'(0), 8'd0,
                 16'h5AA5, 16'h0000);
      // 16-bit read, one dummy, no command: start gives an all-zero word
      send_start(lcdf_pkg::CSZ_NONE, lcdf_pkg::FMT_16, 1'b0, 1'b1, count_type'(2), 8'd1,
                 16'h0000, 16'h0000);
      send_data(lcdf_pkg::MODE_READ, 16'h0000, 8'h77);
      send_start(lcdf_pkg::CSZ_TWO, lcdf_pkg::FMT_8, 1'b0, 1'b0, 24'hFFFFFF, 8'hFF,
                 16'hFFFF, 16'hFFFF);
      send_data(lcdf_pkg::MODE_WRITE, 16'hFFFF, 8'hFF);
      send_data(lcdf_pkg::MODE_READ, 16'h0000, 8'hFF);
      send_data(lcdf_pkg::MODE_READ, 16'h0000, 8'h00);
      send_data(lcdf_pkg::MODE_READ, 16'h0000, 8'h80);
      send_data(lcdf_pkg::MODE_READ, 16'h0000, 8'h01);
      // nothing open: stray read, stray write, unknown mode
      send_data(lcdf_pkg::MODE_READ, 16'h0000, 8'hFF);
      send_data(lcdf_pkg::MODE_WRITE, 16'hFFFF, 8'h00);
      send_data(MODE_BAD, 16'hFFFF, 8'hFF);
      // 888 read back to 565, fill set on a read phase does nothing
      send_start(lcdf_pkg::CSZ_TWO, lcdf_pkg::FMT_RGB, 1'b1, 1'b1, count_type'(1), 8'd0,
                 16'h00FF, 16'hFFFF);
      send_data(lcdf_pkg::MODE_READ, 16'h0000, 8'hFF);
      send_data(lcdf_pkg::MODE_READ, 16'h0000, 8'h00);
      send_data(lcdf_pkg::MODE_READ, 16'h0000, 8'hFF);
      send_start(lcdf_pkg::CSZ_ONE, lcdf_pkg::FMT_8, 1'b0, 1'b0, count_type'(1), 8'd0,
                 16'hABCD, 16'h0000);
      send_data(lcdf_pkg::MODE_WRITE, 16'h00FF, 8'h00);

      // ---- random phases: blue first with the long stall, then a phase
      // with no idles, then random settings ----
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         write_order((ph == 0) ? 1'b0 : (ph == 1) ? 1'b1 : 1'($urandom_range(0, 1)));
         steady = (ph == 1) || ($urandom_range(0, 3) == 0 && ph > 1);
         if (ph == 0)
            hold_pending = 1'b1;
         random_phase(PHASE_ITEMS);
      end

      steady = 1'b0;
      wait_drained();
      if (sb.failures == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
